FILE: hdl/rlre_pkg.sv
package rlre_pkg;

   localparam int CODE_WORD_BITS = 64;
   localparam int SYM_BITS       = 9;
   localparam int EST_BITS       = 10;
   localparam int K_BITS         = 4;
   localparam int NB_BITS        = 4;
   localparam int BV_BITS        = 10;
   localparam int CHANNELS       = 3;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       final_pixel;
   } req_data_type;

   typedef struct packed {
      logic [CODE_WORD_BITS-1:0] code_word;
      logic                      run_end;
      logic                      stream_end;
   } rsp_data_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CODE,
      ST_FLUSH,
      ST_DRAIN
   } state_type;

   localparam logic [1:0] CH_A    = 2'd0;
   localparam logic [1:0] CH_LUMA = 2'd1;
   localparam logic [1:0] CH_C    = 2'd2;

   typedef struct packed {
      logic       load_pixel;
      logic       load_sym;
      logic [1:0] sym_sel;
      logic       step;
      logic       flush;
      logic       drain;
   } cmd_type;

   typedef struct packed {
      logic sym_done;
      logic emit_block;
      logic final_pixel;
   } status_type;

   function automatic logic [K_BITS-1:0] rice_k(input logic [EST_BITS-1:0] est);
      logic [EST_BITS-1:0] v;
      logic [K_BITS-1:0]   k;
      v = (est >> 1) + EST_BITS'(1);
      k = '0;
      for (int i = 1; i < EST_BITS; i++) begin
         if (v[i]) begin
            k = K_BITS'(i);
         end
      end
      return k;
   endfunction

   function automatic logic [SYM_BITS-1:0] zigzag9(input logic [SYM_BITS-1:0] cur,
                                                   input logic [SYM_BITS-1:0] prev);
      logic [SYM_BITS-1:0] d;
      logic [SYM_BITS:0]   z;
      d = cur - prev;
      if (!d[SYM_BITS-1]) begin
         z = {d, 1'b0};
      end else begin
         z = 10'd1023 - {d, 1'b0};
      end
      return z[SYM_BITS-1:0];
   endfunction

   function automatic logic [EST_BITS-1:0] update_est(input logic [EST_BITS-1:0] est,
                                                      input logic [SYM_BITS-1:0] sym);
      logic [11:0] t;
      logic [11:0] s;
      t = {2'b00, sym, 1'b0} + 12'd1024 - {2'b00, est};
      s = {2'b00, est} + (t >> 2) + 12'd768;
      return s[EST_BITS-1:0];
   endfunction

endpackage

FILE: hdl/rgb_lossless_rice_encoder.sv
// Lossless RGB encoder: color transform, previous-pixel prediction and
// adaptive Rice coding of the three channels, packed MSB first into words.
// req channel: one pixel per transaction (red, green, blue, final_pixel).
// rsp channel: one packed code word per transaction; run_end marks the last
// word of a pixel, stream_end the flush word after the final pixel.
// A pixel is accepted only while the encoder is idle. Each channel symbol
// codes its zero run one word-bounded piece per step, then its stop and
// suffix bits (split when they cross a word boundary); a drain step then
// sends the pixel's last word, and a final pixel adds a flush step first.
// A completed word sits in a one-word pending register until the next one
// is known, so a word reaches rsp_valid one word or one pixel end later.
// When the receiver stalls, coding stops at the next word boundary that
// needs the output register, and no transaction is lost.
// Reset clears prediction, estimators and the partial word: a new image.
module rgb_lossless_rice_encoder #(
   parameter int WORD_BITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rlre_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rlre_pkg::rsp_data_type rsp_data
);

   rlre_pkg::cmd_type    cmd;
   rlre_pkg::status_type status;

   rlre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rlre_datapath #(
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/rlre_ctrl.sv
module rlre_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rlre_pkg::status_type status,
   output rlre_pkg::cmd_type    cmd
);

   rlre_pkg::state_type state_ff, state_in;
   logic [1:0]          ch_ff, ch_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rlre_pkg::ST_IDLE;
         ch_ff    <= rlre_pkg::CH_A;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ch_in     = ch_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         rlre_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_pixel = 1'b1;
               ch_in          = rlre_pkg::CH_A;
               state_in       = rlre_pkg::ST_CODE;
            end
         end
         rlre_pkg::ST_CODE: begin
            cmd.step = 1'b1;
            if (status.sym_done) begin
               if (ch_ff == rlre_pkg::CH_C) begin
                  state_in = status.final_pixel ? rlre_pkg::ST_FLUSH : rlre_pkg::ST_DRAIN;
               end else begin
                  cmd.load_sym = 1'b1;
                  cmd.sym_sel  = ch_ff + 2'd1;
                  ch_in        = ch_ff + 2'd1;
               end
            end
         end
         rlre_pkg::ST_FLUSH: begin
            cmd.flush = 1'b1;
            if (!status.emit_block) begin
               state_in = rlre_pkg::ST_DRAIN;
            end
         end
         rlre_pkg::ST_DRAIN: begin
            cmd.drain = 1'b1;
            if (!status.emit_block) begin
               state_in = rlre_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rlre_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/rlre_datapath.sv
module rlre_datapath #(
   parameter int WORD_BITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rlre_pkg::req_data_type req_data,
   input  rlre_pkg::cmd_type      cmd,
   output rlre_pkg::status_type   status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rlre_pkg::rsp_data_type rsp_data
);

   localparam int FreeWidth = $clog2(WORD_BITS + 1);
   localparam logic [FreeWidth-1:0] FullCount = FreeWidth'(WORD_BITS);

   logic [rlre_pkg::SYM_BITS-1:0] prev_a_ff, prev_a_in;
   logic [rlre_pkg::SYM_BITS-1:0] prev_l_ff, prev_l_in;
   logic [rlre_pkg::SYM_BITS-1:0] prev_c_ff, prev_c_in;
   logic [rlre_pkg::EST_BITS-1:0] est_ff [rlre_pkg::CHANNELS];
   logic [rlre_pkg::EST_BITS-1:0] est_in [rlre_pkg::CHANNELS];
   logic [rlre_pkg::SYM_BITS-1:0] sym_ff [rlre_pkg::CHANNELS];
   logic [rlre_pkg::SYM_BITS-1:0] sym_in [rlre_pkg::CHANNELS];
   logic                          final_ff, final_in;
   logic [WORD_BITS-1:0]          acc_ff, acc_in;
   logic [FreeWidth-1:0]          free_ff, free_in;
   logic [rlre_pkg::SYM_BITS-1:0] zrem_ff, zrem_in;
   logic [rlre_pkg::BV_BITS-1:0]  bv_ff, bv_in;
   logic [rlre_pkg::NB_BITS-1:0]  nb_ff, nb_in;
   logic                          pend_valid_ff, pend_valid_in;
   logic [WORD_BITS-1:0]          pend_word_ff, pend_word_in;
   logic                          pend_stream_ff, pend_stream_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rlre_pkg::rsp_data_type        rsp_data_ff, rsp_data_in;

   logic signed [10:0]            a_s, c_s, sum_s;
   logic [rlre_pkg::SYM_BITS-1:0] ua, ul, uc;
   logic [rlre_pkg::SYM_BITS-1:0] s0, s1, s2;
   logic [rlre_pkg::SYM_BITS-1:0] sel_sym;
   logic [rlre_pkg::EST_BITS-1:0] sel_est;
   logic [1:0]                    sel_idx;
   logic [rlre_pkg::K_BITS-1:0]   k;
   logic [rlre_pkg::SYM_BITS-1:0] sym_mask;
   logic [rlre_pkg::SYM_BITS-1:0] zrem_set;
   logic [rlre_pkg::BV_BITS-1:0]  bv_set;
   logic [rlre_pkg::NB_BITS-1:0]  nb_set;
   logic                          load_any;

   logic                          zero_phase;
   logic [rlre_pkg::SYM_BITS-1:0] free_ext;
   logic [rlre_pkg::SYM_BITS-1:0] take_z;
   logic [FreeWidth-1:0]          nb_ext, take_b;
   logic [rlre_pkg::NB_BITS-1:0]  take_b4;
   logic [FreeWidth-1:0]          take;
   logic [FreeWidth-1:0]          free_after;
   logic [rlre_pkg::BV_BITS-1:0]  chunk;
   logic [WORD_BITS-1:0]          placed;
   logic [WORD_BITS-1:0]          word_now;
   logic                          full;
   logic                          out_free;
   logic                          emit_block;
   logic                          step_go, flush_go, drain_go, emit;
   logic [WORD_BITS-1:0]          emit_word;
   logic                          out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff     <= '0;
         prev_l_ff     <= '0;
         prev_c_ff     <= '0;
         for (int i = 0; i < rlre_pkg::CHANNELS; i++) begin
            est_ff[i] <= '0;
         end
         acc_ff        <= '0;
         free_ff       <= FullCount;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prev_a_ff     <= prev_a_in;
         prev_l_ff     <= prev_l_in;
         prev_c_ff     <= prev_c_in;
         for (int i = 0; i < rlre_pkg::CHANNELS; i++) begin
            est_ff[i] <= est_in[i];
         end
         acc_ff        <= acc_in;
         free_ff       <= free_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < rlre_pkg::CHANNELS; i++) begin
         sym_ff[i] <= sym_in[i];
      end
      final_ff       <= final_in;
      zrem_ff        <= zrem_in;
      bv_ff          <= bv_in;
      nb_ff          <= nb_in;
      pend_word_ff   <= pend_word_in;
      pend_stream_ff <= pend_stream_in;
      rsp_data_ff    <= rsp_data_in;
   end

   always_comb begin
      a_s   = $signed({3'b000, req_data.red}) - $signed({3'b000, req_data.green});
      c_s   = $signed({3'b000, req_data.blue}) - $signed({3'b000, req_data.green});
      sum_s = a_s + c_s + 11'sd512;
      ua    = a_s[rlre_pkg::SYM_BITS-1:0];
      uc    = c_s[rlre_pkg::SYM_BITS-1:0];
      ul    = {1'b0, req_data.green} + {1'b0, sum_s[9:2]} - 9'd128;
      s0    = rlre_pkg::zigzag9(ua, prev_a_ff);
      s1    = rlre_pkg::zigzag9(ul, prev_l_ff);
      s2    = rlre_pkg::zigzag9(uc, prev_c_ff);
   end

   always_comb begin
      if (cmd.load_pixel) begin
         sel_idx = rlre_pkg::CH_A;
         sel_sym = s0;
      end else begin
         sel_idx = cmd.sym_sel;
         case (cmd.sym_sel)
            rlre_pkg::CH_LUMA: sel_sym = sym_ff[1];
            rlre_pkg::CH_C:    sel_sym = sym_ff[2];
            default:           sel_sym = sym_ff[0];
         endcase
      end
      case (sel_idx)
         rlre_pkg::CH_LUMA: sel_est = est_ff[1];
         rlre_pkg::CH_C:    sel_est = est_ff[2];
         default:           sel_est = est_ff[0];
      endcase
      k        = rlre_pkg::rice_k(sel_est);
      sym_mask = rlre_pkg::SYM_BITS'((10'd1 << k) - 10'd1);
      zrem_set = sel_sym >> k;
      bv_set   = (10'd1 << k) | {1'b0, sel_sym & sym_mask};
      nb_set   = k + 4'd1;
      load_any = cmd.load_pixel || cmd.load_sym;
   end

   always_comb begin
      zero_phase = (zrem_ff != '0);
      free_ext   = rlre_pkg::SYM_BITS'(free_ff);
      take_z     = (zrem_ff < free_ext) ? zrem_ff : free_ext;
      nb_ext     = FreeWidth'(nb_ff);
      take_b     = (nb_ext < free_ff) ? nb_ext : free_ff;
      take_b4    = rlre_pkg::NB_BITS'(take_b);
      take       = zero_phase ? FreeWidth'(take_z) : take_b;
      free_after = free_ff - take;
      chunk      = (bv_ff >> (nb_ff - take_b4)) & ((10'd1 << take_b4) - 10'd1);
      placed     = WORD_BITS'(chunk) << (free_ff - take_b);
      word_now   = zero_phase ? acc_ff : (acc_ff | placed);
      full       = (free_after == '0);
      out_free   = !rsp_valid_ff || rsp_ready;
      emit_block = pend_valid_ff && !out_free;
      step_go    = cmd.step && !(full && emit_block);
      flush_go   = cmd.flush && !emit_block;
      drain_go   = cmd.drain && pend_valid_ff && out_free;
      emit       = (step_go && full) || flush_go;
      emit_word  = flush_go ? acc_ff : word_now;
      out_load   = (emit && pend_valid_ff) || drain_go;
   end

   always_comb begin
      prev_a_in      = prev_a_ff;
      prev_l_in      = prev_l_ff;
      prev_c_in      = prev_c_ff;
      for (int i = 0; i < rlre_pkg::CHANNELS; i++) begin
         est_in[i] = est_ff[i];
         sym_in[i] = sym_ff[i];
      end
      final_in       = final_ff;
      acc_in         = acc_ff;
      free_in        = free_ff;
      zrem_in        = zrem_ff;
      bv_in          = bv_ff;
      nb_in          = nb_ff;
      pend_valid_in  = pend_valid_ff;
      pend_word_in   = pend_word_ff;
      pend_stream_in = pend_stream_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;

      if (step_go) begin
         acc_in  = full ? '0 : word_now;
         free_in = full ? FullCount : free_after;
         if (zero_phase) begin
            zrem_in = zrem_ff - take_z;
         end else begin
            nb_in = nb_ff - take_b4;
         end
      end

      if (load_any) begin
         zrem_in = zrem_set;
         bv_in   = bv_set;
         nb_in   = nb_set;
         for (int i = 0; i < rlre_pkg::CHANNELS; i++) begin
            if (sel_idx == 2'(i)) begin
               est_in[i] = rlre_pkg::update_est(sel_est, sel_sym);
            end
         end
      end

      if (cmd.load_pixel) begin
         sym_in[0] = s0;
         sym_in[1] = s1;
         sym_in[2] = s2;
         prev_a_in = ua;
         prev_l_in = ul;
         prev_c_in = uc;
         final_in  = req_data.final_pixel;
      end

      if (flush_go) begin
         acc_in    = '0;
         free_in   = FullCount;
         prev_a_in = '0;
         prev_l_in = '0;
         prev_c_in = '0;
         for (int i = 0; i < rlre_pkg::CHANNELS; i++) begin
            est_in[i] = '0;
         end
      end

      if (emit) begin
         pend_valid_in  = 1'b1;
         pend_word_in   = emit_word;
         pend_stream_in = flush_go;
      end else if (drain_go) begin
         pend_valid_in = 1'b0;
      end

      if (out_load) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.code_word  = rlre_pkg::CODE_WORD_BITS'(pend_word_ff);
         rsp_data_in.run_end    = drain_go;
         rsp_data_in.stream_end = drain_go && pend_stream_ff;
      end
   end

   assign status.sym_done    = step_go && !zero_phase && (take_b4 == nb_ff);
   assign status.emit_block  = emit_block;
   assign status.final_pixel = final_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_data_ff;

   a_free_range: assert property (@(posedge clock) disable iff (reset)
      (free_ff != '0) && (free_ff <= FullCount))
      else $error("free bit count out of range");

   a_stream_end_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.stream_end |-> rsp_data_ff.run_end)
      else $error("stream end without run end");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      flush_go |=> (free_ff == FullCount) && (acc_ff == '0))
      else $error("flush did not clear the accumulator");

   a_load_empty_pend: assert property (@(posedge clock) disable iff (reset)
      cmd.load_pixel |-> !pend_valid_ff)
      else $error("pixel loaded with a word still pending");

endmodule

FILE: tb/rice_stream_checker.sv
`timescale 1ns / 100ps
module rice_stream_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  rlre_pkg::req_data_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rlre_pkg::rsp_data_type rsp_data,
   output int                     error_count,
   output int                     pending_count,
   output int                     words_checked
);
   import rlre_pkg::*;

   localparam int WORD_BITS = CODE_WORD_BITS;

   logic [SYM_BITS-1:0] prev_a;
   logic [SYM_BITS-1:0] prev_luma;
   logic [SYM_BITS-1:0] prev_c;
   logic [EST_BITS-1:0] est [CHANNELS];
   logic [63:0]         acc;
   int                  free_bits;
   rsp_data_type        expected_words [$];
   rsp_data_type        pixel_words [$];

   function automatic int rice_param(input logic [EST_BITS-1:0] e);
      int v;
      int k;
      v = int'(e >> 1) + 1;
      k = 0;
      while (v > 1) begin
         v = v >> 1;
         k++;
      end
      return k;
   endfunction

   function automatic logic [SYM_BITS-1:0] residual_symbol(input logic [SYM_BITS-1:0] cur,
                                                           input logic [SYM_BITS-1:0] prev);
      logic [SYM_BITS-1:0] d;
      logic [SYM_BITS:0]   twice;
      logic [SYM_BITS:0]   z;
      d = cur - prev;
      twice = {d, 1'b0};
      if (d[SYM_BITS-1]) begin
         z = 10'd1023 - twice;
      end else begin
         z = twice;
      end
      return z[SYM_BITS-1:0];
   endfunction

   function automatic logic [EST_BITS-1:0] next_estimate(input logic [EST_BITS-1:0] e,
                                                         input logic [SYM_BITS-1:0] sym);
      int t;
      int s;
      t = 2 * int'(sym) - int'(e);
      s = int'(e) + (t >>> 2);
      return s[EST_BITS-1:0];
   endfunction

   task automatic clear_image();
      prev_a = '0;
      prev_luma = '0;
      prev_c = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         est[i] = '0;
      end
      acc = '0;
      free_bits = WORD_BITS;
   endtask

   task automatic push_bit(input logic b);
      rsp_data_type w;
      acc[free_bits-1] = b;
      free_bits--;
      if (free_bits == 0) begin
         w = '0;
         w.code_word = acc;
         pixel_words.push_back(w);
         acc = '0;
         free_bits = WORD_BITS;
      end
   endtask

   task automatic code_symbol_bits(input logic [SYM_BITS-1:0] sym, input int k);
      for (int i = 0; i < int'(sym >> k); i++) begin
         push_bit(1'b0);
      end
      push_bit(1'b1);
      for (int i = k - 1; i >= 0; i--) begin
         push_bit(sym[i]);
      end
   endtask

   task automatic encode_pixel(input req_data_type px);
      int                  a;
      int                  c;
      int                  lum;
      logic [SYM_BITS-1:0] ua;
      logic [SYM_BITS-1:0] ul;
      logic [SYM_BITS-1:0] uc;
      logic [SYM_BITS-1:0] sa;
      logic [SYM_BITS-1:0] sl;
      logic [SYM_BITS-1:0] sc;
      int                  ka;
      int                  kl;
      int                  kc;
      rsp_data_type        w;
      a = int'(px.red) - int'(px.green);
      c = int'(px.blue) - int'(px.green);
      lum = int'(px.green) + ((a + c) >>> 2);
      ua = a[SYM_BITS-1:0];
      ul = lum[SYM_BITS-1:0];
      uc = c[SYM_BITS-1:0];
      ka = rice_param(est[CH_A]);
      kl = rice_param(est[CH_LUMA]);
      kc = rice_param(est[CH_C]);
      sa = residual_symbol(ua, prev_a);
      sl = residual_symbol(ul, prev_luma);
      sc = residual_symbol(uc, prev_c);
      prev_a = ua;
      prev_luma = ul;
      prev_c = uc;
      pixel_words.delete();
      code_symbol_bits(sa, ka);
      code_symbol_bits(sl, kl);
      code_symbol_bits(sc, kc);
      est[CH_A] = next_estimate(est[CH_A], sa);
      est[CH_LUMA] = next_estimate(est[CH_LUMA], sl);
      est[CH_C] = next_estimate(est[CH_C], sc);
      if (px.final_pixel) begin
         w = '0;
         w.code_word = acc;
         w.stream_end = 1'b1;
         pixel_words.push_back(w);
         clear_image();
      end
      if (pixel_words.size() > 0) begin
         w = pixel_words.pop_back();
         w.run_end = 1'b1;
         pixel_words.push_back(w);
      end
      foreach (pixel_words[i]) begin
         expected_words.push_back(pixel_words[i]);
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_data_type want;
      if (reset) begin
         clear_image();
         expected_words.delete();
      end else begin
         if (req_valid && req_ready) begin
            encode_pixel(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected code word %h", rsp_data.code_word);
               error_count++;
            end else begin
               want = expected_words.pop_front();
               words_checked++;
               if (rsp_data.code_word !== want.code_word) begin
                  $error("code_word: expected %h, actual %h", want.code_word,
                         rsp_data.code_word);
                  error_count++;
               end
               if (rsp_data.run_end !== want.run_end) begin
                  $error("run_end: expected %b, actual %b", want.run_end, rsp_data.run_end);
                  error_count++;
               end
               if (rsp_data.stream_end !== want.stream_end) begin
                  $error("stream_end: expected %b, actual %b", want.stream_end,
                         rsp_data.stream_end);
                  error_count++;
               end
            end
         end
      end
      pending_count = expected_words.size();
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
   import rlre_pkg::*;

   localparam int RANDOM_PIXELS = 185;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_data_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_data_type rsp_data;

   int send_idle_pct = 8;
   int recv_idle_pct = 68;
   int error_count;
   int pending_count;
   int words_checked;
   int pixels_sent = 0;
   int images_sent = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   rgb_lossless_rice_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   rice_stream_checker stream_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count),
      .words_checked (words_checked)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic fin);
      req_data_type px;
      px.red = r;
      px.green = g;
      px.blue = b;
      px.final_pixel = fin;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
      if (fin) begin
         images_sent++;
      end
      if (pixels_sent == 95) begin
         send_idle_pct = 68;
         recv_idle_pct = 8;
      end else if (pixels_sent == 165) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   initial begin : stimulus
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      int         mode;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // full-scale residuals: zero runs spanning whole words
      send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);

      // fill exactly one word so the flush word carries no coded bit
      send_pixel(8'd0, 8'd1, 8'd1, 1'b0);
      for (int i = 0; i < 20; i++) begin
         send_pixel(8'd0, 8'd1, 8'd1, i == 19);
      end

      r = 8'($urandom_range(255));
      g = 8'($urandom_range(255));
      b = 8'($urandom_range(255));
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         mode = $urandom_range(99);
         if (mode < 70) begin
            r = r + 8'($urandom_range(6) - 3);
            g = g + 8'($urandom_range(6) - 3);
            b = b + 8'($urandom_range(6) - 3);
         end else if (mode < 88) begin
            r = 8'($urandom_range(255));
            g = 8'($urandom_range(255));
            b = 8'($urandom_range(255));
         end else begin
            r = $urandom_range(1) ? 8'd255 : 8'd0;
            g = $urandom_range(1) ? 8'd255 : 8'd0;
            b = $urandom_range(1) ? 8'd255 : 8'd0;
         end
         send_pixel(r, g, b, ($urandom_range(24) == 0) || (i == RANDOM_PIXELS - 1));
      end
      req_valid <= 1'b0;

      @(posedge clock);
      wait (pending_count == 0);
      repeat (40) @(posedge clock);
      $display("Encoded %0d pixels in %0d images and compared %0d code words,", pixels_sent,
               images_sent, words_checked);
      $display("including full-scale residuals, an empty flush word and three pacing mixes.");
      if (error_count == 0 && pending_count == 0) begin
         $display("[rgb_lossless_rice_encoder] OK");
      end else begin
         $display("[rgb_lossless_rice_encoder] ERROR");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("[rgb_lossless_rice_encoder] ERROR");
      $finish;
   end

endmodule
